// File: rtl/core/udprx_pkg.sv
package udprx_pkg;

  localparam int unsigned CntW     = 12;
  localparam int unsigned MaxFrame = 2048;

  localparam logic [CntW-1:0] MAX_FRAME = CntW'(MaxFrame);

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_ARP    = 16'h0806;
  localparam logic [7:0]  VHL_V4_NOOPT = 8'((4 << 4) | (20 >> 2));
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [31:0] BCAST_ADDR   = 32'hffff_ffff;
  localparam logic [15:0] CKSUM_GOOD   = 16'hffff;

  // byte offsets inside the frame
  localparam logic [CntW-1:0] OFS_IP_HDR  = CntW'(14);
  localparam logic [CntW-1:0] OFS_IP_END  = CntW'(33);
  localparam logic [CntW-1:0] OFS_UDP_HDR = CntW'(34);
  localparam logic [CntW-1:0] OFS_PAYLOAD = CntW'(42);

  typedef enum logic [3:0] {
    V_DELIVER  = 4'd0,
    V_ARP      = 4'd1,
    V_SHORT    = 4'd2,
    V_UNKNOWN  = 4'd3,
    V_BAD_VER  = 4'd4,
    V_BAD_CKS  = 4'd5,
    V_FRAGMENT = 4'd6,
    V_NOT_OURS = 4'd7,
    V_NOT_UDP  = 4'd8,
    V_LEN_MISM = 4'd9,
    V_TRUNC    = 4'd10
  } verdict_e;

  // header fields of one finished frame
  typedef struct packed {
    logic [CntW-1:0] len;
    logic [15:0]     ether_type;
    logic [7:0]      version_ihl;
    logic [15:0]     checksum;
    logic [15:0]     fragment;
    logic [7:0]      protocol;
    logic [15:0]     total_length;
    logic [31:0]     src_address;
    logic [31:0]     dst_address;
    logic [31:0]     udp_ports;
    logic [15:0]     udp_length;
  } hdr_t;

endpackage

// File: rtl/core/udprx_byte_if.sv
interface udprx_byte_if;
  import udprx_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// File: rtl/core/udprx_result_if.sv
interface udprx_result_if;
  import udprx_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [31:0] source_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] payload_length;

  modport source (
    output valid, output verdict, output source_addr, output source_port,
    output dest_port, output payload_length, input ready
  );
  modport sink (
    input valid, input verdict, input source_addr, input source_port,
    input dest_port, input payload_length, output ready
  );
endinterface

// File: rtl/core/udprx_capture.sv
module udprx_capture
  import udprx_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  udprx_byte_if.sink   rx_i,
  input  logic         snap_ready_i,
  output logic         snap_valid_o,
  output hdr_t         snap_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      pend_q, pend_d;
  hdr_t            st_q, st_d;
  logic            snap_vld_q, snap_vld_d;
  hdr_t            snap_q;
  logic            acc;
  logic [CntW-1:0] pos;
  logic [7:0]      b;
  logic [16:0]     sum;

  assign rx_i.ready = !snap_vld_q || snap_ready_i;
  assign acc        = rx_i.valid && rx_i.ready;
  assign pos        = cnt_q;
  assign b          = rx_i.frame_byte;
  assign sum        = {1'b0, st_q.checksum} + {1'b0, pend_q, b};

  always_comb begin
    st_d   = st_q;
    pend_d = pend_q;
    cnt_d  = (cnt_q < MAX_FRAME) ? cnt_q + CntW'(1) : cnt_q;
    st_d.len = cnt_d;
    if (pos == CntW'(12) || pos == CntW'(13)) begin
      st_d.ether_type = {st_q.ether_type[7:0], b};
    end
    if (pos >= OFS_IP_HDR && pos <= OFS_IP_END) begin
      if (!pos[0]) begin
        pend_d = b;
      end else begin
        // end-around carry
        st_d.checksum = sum[15:0] + {15'd0, sum[16]};
      end
    end
    if (pos == OFS_IP_HDR) begin
      st_d.version_ihl = b;
    end
    if (pos == CntW'(16) || pos == CntW'(17)) begin
      st_d.total_length = {st_q.total_length[7:0], b};
    end
    if (pos == CntW'(20) || pos == CntW'(21)) begin
      st_d.fragment = {st_q.fragment[7:0], b};
    end
    if (pos == CntW'(23)) begin
      st_d.protocol = b;
    end
    if (pos >= CntW'(26) && pos <= CntW'(29)) begin
      st_d.src_address = {st_q.src_address[23:0], b};
    end
    if (pos >= CntW'(30) && pos <= OFS_IP_END) begin
      st_d.dst_address = {st_q.dst_address[23:0], b};
    end
    if (pos >= OFS_UDP_HDR && pos <= CntW'(37)) begin
      st_d.udp_ports = {st_q.udp_ports[23:0], b};
    end
    if (pos == CntW'(38) || pos == CntW'(39)) begin
      st_d.udp_length = {st_q.udp_length[7:0], b};
    end
  end

  always_comb begin
    snap_vld_d = snap_vld_q;
    if (snap_vld_q && snap_ready_i) begin
      snap_vld_d = 1'b0;
    end
    if (acc && rx_i.frame_end) begin
      snap_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pend_q     <= '0;
      st_q       <= '0;
      snap_vld_q <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
      if (acc) begin
        if (rx_i.frame_end) begin
          cnt_q  <= '0;
          pend_q <= '0;
          st_q   <= '0;
        end else begin
          cnt_q  <= cnt_d;
          pend_q <= pend_d;
          st_q   <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && rx_i.frame_end) begin
      snap_q <= st_d;
    end
  end

  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;

`ifndef ASSERT_OFF
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_FRAME)
    else $error("byte count above saturation limit");
  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && rx_i.frame_end |=> cnt_q == '0 && st_q.ether_type == '0 && snap_vld_q)
    else $error("frame state not cleared after last word");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !snap_vld_q |-> rx_i.ready)
    else $error("input stalled with empty header stage");
`endif

endmodule

// File: rtl/core/udprx_judge.sv
module udprx_judge
  import udprx_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    local_ip_i,
  input  logic           snap_valid_i,
  input  hdr_t           snap_i,
  output logic           snap_ready_o,
  udprx_result_if.source res_o
);

  verdict_e    vd;
  logic [15:0] expect_len;
  logic [15:0] pay;
  logic [15:0] room;
  logic        load;

  logic        out_vld_q;
  verdict_e    vd_q;
  logic [31:0] src_q;
  logic [15:0] sport_q, dport_q, pay_q;

  assign snap_ready_o = !out_vld_q || res_o.ready;
  assign load         = snap_valid_i && snap_ready_o;

  assign expect_len = snap_i.total_length - 16'd20;
  assign pay        = expect_len - 16'd8;
  assign room       = {{(16-CntW){1'b0}}, snap_i.len} - {{(16-CntW){1'b0}}, OFS_PAYLOAD};

  always_comb begin
    if (snap_i.len < OFS_IP_HDR) begin
      vd = V_SHORT;
    end else if (snap_i.ether_type == ETYPE_ARP) begin
      vd = V_ARP;
    end else if (snap_i.ether_type != ETYPE_IPV4) begin
      vd = V_UNKNOWN;
    end else if (snap_i.len < OFS_UDP_HDR) begin
      vd = V_SHORT;
    end else if (snap_i.version_ihl != VHL_V4_NOOPT) begin
      vd = V_BAD_VER;
    end else if (snap_i.checksum != CKSUM_GOOD) begin
      vd = V_BAD_CKS;
    end else if (snap_i.fragment != 16'd0) begin
      vd = V_FRAGMENT;
    end else if (snap_i.dst_address != BCAST_ADDR && snap_i.dst_address != local_ip_i) begin
      vd = V_NOT_OURS;
    end else if (snap_i.protocol != PROTO_UDP) begin
      vd = V_NOT_UDP;
    end else if (snap_i.len < OFS_PAYLOAD) begin
      vd = V_SHORT;
    end else if (snap_i.udp_length != expect_len) begin
      vd = V_LEN_MISM;
    end else if (pay > room) begin
      vd = V_TRUNC;
    end else begin
      vd = V_DELIVER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vd_q <= vd;
      if (vd == V_DELIVER) begin
        src_q   <= snap_i.src_address;
        sport_q <= snap_i.udp_ports[31:16];
        dport_q <= snap_i.udp_ports[15:0];
        pay_q   <= pay;
      end else begin
        src_q   <= '0;
        sport_q <= '0;
        dport_q <= '0;
        pay_q   <= '0;
      end
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.verdict        = vd_q;
  assign res_o.source_addr    = src_q;
  assign res_o.source_port    = sport_q;
  assign res_o.dest_port      = dport_q;
  assign res_o.payload_length = pay_q;

`ifndef ASSERT_OFF
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.verdict != V_DELIVER |->
      res_o.source_addr == '0 && res_o.source_port == '0 &&
      res_o.dest_port == '0 && res_o.payload_length == '0)
    else $error("dropped frame carries header fields");
  a_pay_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.verdict == V_DELIVER |->
      res_o.payload_length <= 16'(MaxFrame - 42))
    else $error("payload length beyond frame");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_vld_q)
    else $error("verdict lost after header stage handoff");
`endif

endmodule

// File: rtl/core/eth_ipv4_udp_rx_filter.sv
// Ethernet/IPv4/UDP receive filter. Frame bytes enter on rx_i (frame_end high
// on the last byte), and every frame yields exactly one result word on res_o
// when its last byte has gone through: a verdict code (udp deliver, arp,
// short, unknown type, bad version, bad checksum, fragment, not ours, not
// udp, udp length mismatch, udp truncated) plus source address, ports and
// udp payload length, which are zero for any verdict but deliver. Throughput
// is one byte per clock while rx_i.ready is high; the byte counter, field
// capture and 16-bit end-around checksum adder are the work per byte. The
// finished header is latched, then the verdict registered. Byte count
// saturates at 2048. local_ip is written through cfg_we_i/cfg_wdata_i; the
// user must do so only while no frame is in flight, unenforced by the block.
module eth_ipv4_udp_rx_filter
  import udprx_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  udprx_byte_if.sink     rx_i,
  udprx_result_if.source res_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);

  // local ip register, host byte order
  logic [31:0] local_ip_q;

  // handoff between header capture and verdict stage
  logic snap_valid;
  logic snap_ready;
  hdr_t snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
    end else if (cfg_we_i) begin
      local_ip_q <= cfg_wdata_i;
    end
  end

  // byte counter, field capture and checksum accumulation
  udprx_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .snap_ready_i (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  // verdict decision and result register
  udprx_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .local_ip_i   (local_ip_q),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .res_o        (res_o)
  );

endmodule
